[hw/rtl/srlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srlc_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 4;
  localparam int unsigned COUNT_W    = 5;

  // Command codes carried in the opcode field of a command beat.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_NEXT   = 2'd1,
    OP_PREV   = 2'd2,
    OP_NOP    = 2'd3
  } srlc_op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_REPLY = 1'b1
  } srlc_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                       insert_en;
    logic signed [VALUE_W-1:0]  value;
  } srlc_bcast_t;

  // What a cell hands to its upper neighbour.
  typedef struct packed {
    logic signed [VALUE_W-1:0]  entry;
    logic                       le;
  } srlc_link_t;

endpackage

`default_nettype wire

[hw/rtl/srlc_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface srlc_cmd_if;
  import srlc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

[hw/rtl/srlc_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface srlc_rsp_if;
  import srlc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  cursor_value;
  logic [POSITION_W-1:0]      cursor_position;
  logic                       list_empty;
  logic                       insert_dropped;
  logic [COUNT_W-1:0]         entry_count;

  modport source (output valid, output cursor_value, output cursor_position,
                  output list_empty, output insert_dropped, output entry_count,
                  input ready);
  modport sink   (input valid, input cursor_value, input cursor_position,
                  input list_empty, input insert_dropped, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/sorted_ring_list_with_cursor.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Beat contents
// --------+-----+--------------------------------------------------------------
// cmd     | in  | opcode (insert, next, previous, no-op), signed 32-bit value
// rsp     | out | cursor value, cursor position, empty, dropped, entry count
//
// A command beat updates the cells, the fill count and the cursor at its accepting
// edge; the response is then gathered into the output register once it is free,
// and a command can be taken every cycle while responses drain.
// Reset clears the fill count, the cursor and the handshake state but not the cells,
// as entries above the fill count are never read. A stalled response holds its beat;
// one more command may be taken while it waits, then the chain stalls until it frees.

module sorted_ring_list_with_cursor #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  srlc_cmd_if.sink         cmd,
  srlc_rsp_if.source       rsp
);
  import srlc_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  srlc_state_t state, state_next;

  logic [CW-1:0]  count, count_next;
  logic [IW-1:0]  cursor, cursor_next;
  logic           dropped;

  logic                       rsp_valid;
  logic signed [VALUE_W-1:0]  rsp_value;
  logic [POSITION_W-1:0]      rsp_position;
  logic                       rsp_empty;
  logic                       rsp_dropped;
  logic [COUNT_W-1:0]         rsp_count;

  logic accept;
  logic load;
  logic is_full;
  logic is_insert;

  srlc_bcast_t                bcast;
  srlc_link_t                 links [CAPACITY+1];
  logic [CAPACITY-1:0]        occupied;
  logic [CAPACITY-1:0]        place;

  logic [IW-1:0]              insert_pos;
  logic signed [VALUE_W-1:0]  gathered;

  // Handshake: the result register frees up when it is empty or being taken.
  assign load      = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_insert = (cmd.opcode == OP_INSERT);

  // The chain of cells. Cell zero sees a virtual lower neighbour that always
  // compares as less or equal, so an insert below every entry lands there.
  assign links[0] = '{entry: '0, le: 1'b1};
  assign bcast    = '{insert_en: accept && is_insert && !is_full, value: cmd.value};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count);

    srlc_cell u_cell (
      .clk      (clk),
      .bcast    (bcast),
      .occupied (occupied[i]),
      .prev     (links[i]),
      .link     (links[i+1]),
      .place    (place[i])
    );
  end

  // Index of the cell that takes the new value: the place bits are one-hot
  // whenever the list has room.
  always_comb begin
    insert_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (place[i]) begin
        insert_pos = insert_pos | IW'(i);
      end
    end
  end

  // Entry under the cursor, read from the registered cells.
  always_comb begin
    gathered = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IW'(i) == cursor) begin
        gathered = gathered | links[i+1].entry;
      end
    end
  end

  // Fill count and cursor follow the command at the accepting edge.
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    if (accept) begin
      unique case (srlc_op_t'(cmd.opcode))
        OP_INSERT: begin
          if (!is_full) begin
            count_next  = count + CW'(1);
            cursor_next = insert_pos;
          end
        end
        OP_NEXT: begin
          if (count != '0) begin
            cursor_next = ((CW'(cursor) + CW'(1)) >= count) ? '0 : cursor + IW'(1);
          end
        end
        OP_PREV: begin
          if (count != '0) begin
            cursor_next = (cursor == '0) ? IW'(count - CW'(1)) : cursor - IW'(1);
          end
        end
        OP_NOP: begin
          cursor_next = cursor;
        end
        default: begin
          cursor_next = cursor;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (load) state_next = accept ? ST_REPLY : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine: a command is taken when idle, or in the
  // same cycle that the pending response moves into the output register.
  always_comb begin
    unique case (state)
      ST_IDLE:  cmd.ready = 1'b1;
      ST_REPLY: cmd.ready = load;
      default:  cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (state == ST_REPLY && load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Per-command flag carried from the accepting edge to the response.
  always_ff @(posedge clk) begin
    if (accept) begin
      dropped <= is_insert && is_full;
    end
  end

  // Response payload, built from the state the command left behind.
  always_ff @(posedge clk) begin
    if (state == ST_REPLY && load) begin
      rsp_empty    <= (count == '0);
      rsp_value    <= (count == '0) ? '0 : gathered;
      rsp_position <= (count == '0) ? '0 : POSITION_W'(cursor);
      rsp_dropped  <= dropped;
      rsp_count    <= COUNT_W'(count);
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.cursor_value    = rsp_value;
  assign rsp.cursor_position = rsp_position;
  assign rsp.list_empty      = rsp_empty;
  assign rsp.insert_dropped  = rsp_dropped;
  assign rsp.entry_count     = rsp_count;

endmodule

`default_nettype wire

[hw/rtl/srlc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module srlc_cell (
  input  logic                 clk,
  input  srlc_pkg::srlc_bcast_t bcast,
  input  logic                 occupied,
  input  srlc_pkg::srlc_link_t prev,
  output srlc_pkg::srlc_link_t link,
  output logic                 place
);
  import srlc_pkg::*;

  logic signed [VALUE_W-1:0] entry;
  logic                      le;

  // The list is ascending, so the le bits form a prefix along the chain and
  // the new value lands in the first cell whose entry is greater or that is empty.
  always_comb begin
    le    = occupied && (entry <= bcast.value);
    place = !le && prev.le;
    link  = '{entry: entry, le: le};
  end

  always_ff @(posedge clk) begin
    if (bcast.insert_en && !le) begin
      entry <= prev.le ? bcast.value : prev.entry;
    end
  end

endmodule

`default_nettype wire

[bench/srlc_cursor_checker.sv]
`timescale 1ns / 1ps

module srlc_cursor_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic   clk,
  input  logic   rst,
  srlc_cmd_if    cmd,
  srlc_rsp_if    rsp,
  output int     fail_count,
  output int     outstanding
);
  import srlc_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] cursor_value;
    logic [POSITION_W-1:0]     cursor_position;
    logic                      list_empty;
    logic                      insert_dropped;
    logic [COUNT_W-1:0]        entry_count;
  } cursor_report_t;

  // Mirror of the list: ascending entries, fill level and cursor.
  logic signed [VALUE_W-1:0] ring_entries [CAPACITY];
  int unsigned               ring_fill;
  int unsigned               ring_cursor;

  cursor_report_t expected_reports [$];
  int             mismatches;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
    ring_fill   = 0;
    ring_cursor = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] srlc mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Applies one command to the mirror and returns the report it should produce.
  function automatic cursor_report_t advance_ring(srlc_op_t op,
                                                  logic signed [VALUE_W-1:0] val);
    cursor_report_t rep;
    int unsigned    slot;
    int unsigned    i;
    rep.insert_dropped = 1'b0;
    case (op)
      OP_INSERT: begin
        if (ring_fill >= CAPACITY) begin
          rep.insert_dropped = 1'b1;
        end else begin
          slot = 0;
          while (slot < ring_fill && ring_entries[slot] <= val) slot++;
          for (i = ring_fill; i > slot; i--) ring_entries[i] = ring_entries[i-1];
          ring_entries[slot] = val;
          ring_fill++;
          ring_cursor = slot;
        end
      end
      OP_NEXT: begin
        if (ring_fill > 0) ring_cursor = (ring_cursor + 1 >= ring_fill) ? 0 : ring_cursor + 1;
      end
      OP_PREV: begin
        if (ring_fill > 0) ring_cursor = (ring_cursor == 0) ? ring_fill - 1 : ring_cursor - 1;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
    if (ring_fill == 0 || ring_cursor >= ring_fill) begin
      rep.cursor_value    = '0;
      rep.cursor_position = '0;
    end else begin
      rep.cursor_value    = ring_entries[ring_cursor];
      rep.cursor_position = ring_cursor[POSITION_W-1:0];
    end
    rep.list_empty  = (ring_fill == 0);
    rep.entry_count = ring_fill[COUNT_W-1:0];
    return rep;
  endfunction

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst) begin
      ring_fill   = 0;
      ring_cursor = 0;
      expected_reports.delete();
    end else begin
      // Responses first: a response never belongs to a command taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        got.cursor_value    = rsp.cursor_value;
        got.cursor_position = rsp.cursor_position;
        got.list_empty      = rsp.list_empty;
        got.insert_dropped  = rsp.insert_dropped;
        got.entry_count     = rsp.entry_count;
        if (expected_reports.size() == 0) begin
          report_mismatch("response beat with no command waiting");
        end else begin
          want = expected_reports.pop_front();
          if (got.cursor_value !== want.cursor_value)
            report_mismatch($sformatf("cursor_value got %0d expected %0d",
                                      got.cursor_value, want.cursor_value));
          if (got.cursor_position !== want.cursor_position)
            report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                      got.cursor_position, want.cursor_position));
          if (got.list_empty !== want.list_empty)
            report_mismatch($sformatf("list_empty got %b expected %b",
                                      got.list_empty, want.list_empty));
          if (got.insert_dropped !== want.insert_dropped)
            report_mismatch($sformatf("insert_dropped got %b expected %b",
                                      got.insert_dropped, want.insert_dropped));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      got.entry_count, want.entry_count));
        end
      end
      if (cmd.valid && cmd.ready)
        expected_reports.push_back(advance_ring(srlc_op_t'(cmd.opcode), cmd.value));
    end
    outstanding <= expected_reports.size();
    fail_count  <= mismatches;
  end

endmodule

[bench/tb_sorted_ring_list_with_cursor.sv]
`timescale 1ns / 1ps

module tb_sorted_ring_list_with_cursor;
  import srlc_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int          RANDOM_ITEMS = 1725;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 400;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic hold_off = 1'b0;

  int items_sent  = 0;
  int cycle_count = 0;
  int fail_count;
  int outstanding;

  srlc_cmd_if cmd_ch ();
  srlc_rsp_if rsp_ch ();

  sorted_ring_list_with_cursor #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // The checker watches both channels, keeps its own copy of the list and
  // compares every response beat against the oldest prediction.
  srlc_cursor_checker #(
    .CAPACITY (CAPACITY)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Both sides stop idling for a while in the middle of the run, so that there is
  // a long stretch of back-to-back beats in each direction.
  wire calm = (items_sent >= 900) && (items_sent < 1200);

  // Each side idles with a chance of seventeen in a hundred at every roll, outside
  // the calm stretch.
  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  // Values for inserts: a quarter are corner values (the extremes of the signed
  // range, zero and minus one), a quarter come from a narrow band around zero so
  // that equal values turn up often, and the rest are uniform over all 32 bits.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1: v = int'($urandom_range(16)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one command beat and returns once it has been taken. Any idle
  // cycles come before the beat, so valid is never lowered and raised again
  // within the same time step.
  task automatic send_command(srlc_op_t op, logic signed [VALUE_W-1:0] val);
    while (roll_idle()) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.value  <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Response side. Ready is dropped at random, and held low throughout the
  // hold-off so that the block fills up and pushes back on the command side.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= !hold_off && !roll_idle();
    end
  end

  // The long hold-off is timed in its own process while the sender carries on
  // offering commands.
  initial begin
    wait (items_sent >= 500);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sorted_ring_list_with_cursor verification failed");
    $finish;
  end

  initial begin
    int  r;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.opcode <= OP_NOP;
    cmd_ch.value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Cursor moves and a no-op on the empty list must change nothing.
    send_command(OP_NEXT, VALUE_MAX);
    send_command(OP_PREV, -1);
    send_command(OP_NOP, '0);

    // Equal values land after their twins; the minimum arriving once three
    // entries are held must still go to the head of the ring.
    send_command(OP_INSERT, 5);
    send_command(OP_INSERT, 5);
    send_command(OP_INSERT, 100);
    send_command(OP_INSERT, VALUE_MIN);

    // The cursor sits on the smallest entry, so prev wraps to the largest and
    // next wraps straight back.
    send_command(OP_PREV, '0);
    send_command(OP_NEXT, '0);
    send_command(OP_INSERT, VALUE_MAX);
    send_command(OP_NEXT, -1);
    send_command(OP_INSERT, 5);
    send_command(OP_INSERT, VALUE_MIN);
    send_command(OP_INSERT, -1);
    send_command(OP_NOP, 32'sh5555_5555);
    send_command(OP_INSERT, '0);

    // Fill the remaining places, then try one insert too many.
    repeat (CAPACITY - 9) send_command(OP_INSERT, int'($urandom_range(16)) - 8);
    send_command(OP_INSERT, VALUE_MAX);
    send_command(OP_PREV, VALUE_MIN);

    // Random part: mostly cursor moves around the full ring, with dropped
    // inserts and no-ops mixed in.
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 10)
        send_command(OP_INSERT, pick_value());
      else if (r < 15)
        send_command(OP_NOP, $urandom);
      else if (r < 57)
        send_command(OP_NEXT, $urandom);
      else
        send_command(OP_PREV, $urandom);
    end
    cmd_ch.valid <= 1'b0;

    // One edge so that the checker has counted the last beat, then drain.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("sorted_ring_list_with_cursor verification clean");
    end else begin
      $display("sorted_ring_list_with_cursor verification failed");
    end
    $finish;
  end

endmodule
